[rtl/nrg_pkg.sv]
// Shared constants, codes and sequencer types for the nearest-neighbour resize gather.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package nrg_pkg;

  // Default sizing
  localparam int STORE_DEPTH_DEF  = 4096;
  localparam int MAX_DIM_DEF      = 256;
  localparam int MAX_CHANNELS_DEF = 64;

  // Fixed field widths
  localparam int CMD_W      = 1;
  localparam int LOAD_IDX_W = 12;
  localparam int PIXEL_W    = 16;
  localparam int OUT_IDX_W  = 22;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_CFG_W  = 9;
  localparam int CH_CFG_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_EMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_READ,
    ST_RESP
  } seq_state_e;

  typedef struct packed {
    logic in_stall;
    logic mul1_en;
    logic mul2_en;
    logic sum_en;
    logic rd_en;
    logic resp_en;
  } seq_ctrl_t;

endpackage

[rtl/nearest_resize_gather_unit.sv]
// Top level of the nearest-neighbour resize gather: configuration, counters, sequencer.
// Depends on nrg_pkg, nrg_coord and nrg_store.
`timescale 1ns / 1ps

// A load item (cmd 0) writes one fp16 pixel into the local store; it gives no result
// unless its index lies beyond the store, in which case one result with load_error set
// is registered from the response state. An emit item (cmd 1) gives the next output pixel
// of the channel/row/column walk, its linear output index and a last flag. Its result is
// formed by the source row and column division, which resolves one quotient bit per cycle,
// followed by two multiply stages, an add stage and the store read. One item is worked on
// at a time; a result waiting in the output register does not block the next item. Store
// entries must be written before an emit reads them.
module nearest_resize_gather_unit #(
  parameter int STORE_DEPTH  = nrg_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DIM      = nrg_pkg::MAX_DIM_DEF,
  parameter int MAX_CHANNELS = nrg_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [nrg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nrg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [nrg_pkg::CMD_W-1:0]         cmd_i,
  input  logic [nrg_pkg::LOAD_IDX_W-1:0]    load_index_i,
  input  logic [nrg_pkg::PIXEL_W-1:0]       load_pixel_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [nrg_pkg::PIXEL_W-1:0]       out_pixel_o,
  output logic [nrg_pkg::OUT_IDX_W-1:0]     out_index_o,
  output logic                              last_pixel_o,
  output logic                              load_error_o
);

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CC_W   = $clog2(MAX_CHANNELS + 1);
  localparam int PCH_W  = CH_W + DIM_W;
  localparam int PRW_W  = CNT_W + DIM_W;
  localparam int SIDX_W = CC_W + 2 * DIM_W;

  function automatic logic [31:0] clamp_val(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers (effective values)
  logic [DIM_W-1:0] in_h_q, in_w_q, out_h_q, out_w_q;
  logic [CC_W-1:0]  chans_q;
  logic [DIM_W-1:0] dim_val;
  logic [CC_W-1:0]  chan_val;

  assign dim_val  = DIM_W'(clamp_val(32'(cfg_data_i), 32'(MAX_DIM)));
  assign chan_val = CC_W'(clamp_val(32'(cfg_data_i[nrg_pkg::CH_CFG_W-1:0]),
                                    32'(MAX_CHANNELS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_h_q  <= DIM_W'(1);
      in_w_q  <= DIM_W'(1);
      out_h_q <= DIM_W'(1);
      out_w_q <= DIM_W'(1);
      chans_q <= CC_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nrg_pkg::REG_IN_HEIGHT:     in_h_q  <= dim_val;
        nrg_pkg::REG_IN_WIDTH:      in_w_q  <= dim_val;
        nrg_pkg::REG_OUT_HEIGHT:    out_h_q <= dim_val;
        nrg_pkg::REG_OUT_WIDTH:     out_w_q <= dim_val;
        nrg_pkg::REG_CHANNEL_COUNT: chans_q <= chan_val;
        default: ;
      endcase
    end
  end

  // sequencer
  nrg_pkg::seq_state_e state_q, state_d;
  nrg_pkg::seq_ctrl_t  ctrl;

  logic in_acc, is_emit, load_bad, out_free;
  logic row_done, col_done;
  logic [CNT_W-1:0] src_row, src_col;

  assign in_acc   = in_valid_i && !ctrl.in_stall;
  assign is_emit  = (cmd_i == nrg_pkg::CMD_EMIT);
  assign load_bad = 64'(load_index_i) >= 64'(STORE_DEPTH);
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nrg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_emit) begin
            state_d = nrg_pkg::ST_DIV;
          end else if (load_bad) begin
            state_d = nrg_pkg::ST_RESP;
          end
        end
      end
      nrg_pkg::ST_DIV:  if (row_done && col_done) state_d = nrg_pkg::ST_MUL1;
      nrg_pkg::ST_MUL1: state_d = nrg_pkg::ST_MUL2;
      nrg_pkg::ST_MUL2: state_d = nrg_pkg::ST_SUM;
      nrg_pkg::ST_SUM:  state_d = nrg_pkg::ST_READ;
      nrg_pkg::ST_READ: state_d = nrg_pkg::ST_RESP;
      nrg_pkg::ST_RESP: if (out_free) state_d = nrg_pkg::ST_IDLE;
      default:          state_d = nrg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.in_stall = (state_q != nrg_pkg::ST_IDLE);
    unique case (state_q)
      nrg_pkg::ST_MUL1: ctrl.mul1_en = 1'b1;
      nrg_pkg::ST_MUL2: ctrl.mul2_en = 1'b1;
      nrg_pkg::ST_SUM:  ctrl.sum_en  = 1'b1;
      nrg_pkg::ST_READ: ctrl.rd_en   = 1'b1;
      nrg_pkg::ST_RESP: ctrl.resp_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nrg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = ctrl.in_stall;

  // walk counters
  logic [CH_W-1:0]  chan_q;
  logic [CNT_W-1:0] row_q, col_q;
  logic col_end, row_end, chan_end;

  assign col_end  = (DIM_W'(col_q) + DIM_W'(1)) >= out_w_q;
  assign row_end  = (DIM_W'(row_q) + DIM_W'(1)) >= out_h_q;
  assign chan_end = (CC_W'(chan_q) + CC_W'(1)) >= chans_q;

  logic err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        err_q <= !is_emit && load_bad;
      end
      if (ctrl.resp_en && !err_q) begin
        if (!col_end) begin
          col_q <= col_q + CNT_W'(1);
        end else begin
          col_q <= '0;
          if (!row_end) begin
            row_q <= row_q + CNT_W'(1);
          end else begin
            row_q  <= '0;
            chan_q <= chan_end ? '0 : chan_q + CH_W'(1);
          end
        end
      end
    end
  end

  // source coordinates
  nrg_coord #(
    .MAX_DIM (MAX_DIM)
  ) u_row_coord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && is_emit),
    .pos_i   (row_q),
    .n_in_i  (in_h_q),
    .n_out_i (out_h_q),
    .done_o  (row_done),
    .coord_o (src_row)
  );

  nrg_coord #(
    .MAX_DIM (MAX_DIM)
  ) u_col_coord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && is_emit),
    .pos_i   (col_q),
    .n_in_i  (in_w_q),
    .n_out_i (out_w_q),
    .done_o  (col_done),
    .coord_o (src_col)
  );

  // linear index datapath
  logic [PCH_W-1:0]  s_ch_q, o_ch_q;
  logic [PRW_W-1:0]  s_rw_q, o_rw_q;
  logic [CNT_W-1:0]  sc_q;
  logic [SIDX_W-1:0] s_prod_q, o_prod_q, sidx_q;
  logic [nrg_pkg::OUT_IDX_W-1:0] oidx_q;
  logic in_range, in_range_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.mul1_en) begin
      s_ch_q <= PCH_W'(chan_q) * PCH_W'(in_h_q);
      o_ch_q <= PCH_W'(chan_q) * PCH_W'(out_h_q);
      s_rw_q <= PRW_W'(src_row) * PRW_W'(in_w_q);
      o_rw_q <= PRW_W'(row_q) * PRW_W'(out_w_q);
      sc_q   <= src_col;
    end
    if (ctrl.mul2_en) begin
      s_prod_q <= SIDX_W'(s_ch_q) * SIDX_W'(in_w_q);
      o_prod_q <= SIDX_W'(o_ch_q) * SIDX_W'(out_w_q);
    end
    if (ctrl.sum_en) begin
      sidx_q <= s_prod_q + SIDX_W'(s_rw_q) + SIDX_W'(sc_q);
      oidx_q <= nrg_pkg::OUT_IDX_W'(o_prod_q + SIDX_W'(o_rw_q) + SIDX_W'(col_q));
    end
    if (ctrl.rd_en) begin
      in_range_q <= in_range;
    end
  end

  assign in_range = 64'(sidx_q) < 64'(STORE_DEPTH);

  // store
  logic [nrg_pkg::PIXEL_W-1:0] rd_data;

  nrg_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !is_emit && !load_bad),
    .waddr_i (AW'(load_index_i)),
    .wdata_i (load_pixel_i),
    .re_i    (ctrl.rd_en && in_range),
    .raddr_i (AW'(sidx_q)),
    .rdata_o (rd_data)
  );

  // output register
  logic                          out_valid_q;
  logic [nrg_pkg::PIXEL_W-1:0]   out_pixel_q;
  logic [nrg_pkg::OUT_IDX_W-1:0] out_index_q;
  logic                          last_q;
  logic                          error_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.resp_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.resp_en) begin
      if (err_q) begin
        out_pixel_q <= '0;
        out_index_q <= '0;
        last_q      <= 1'b0;
      end else begin
        out_pixel_q <= in_range_q ? rd_data : '0;
        out_index_q <= oidx_q;
        last_q      <= col_end && row_end && chan_end;
      end
      error_q <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign out_index_o  = out_index_q;
  assign last_pixel_o = last_q;
  assign load_error_o = error_q;

endmodule

[rtl/nrg_coord.sv]
// Source coordinate unit: floor(((2*o+1)*n_in - 1) / (2*n_out)), clamped to n_in-1.
// Restoring division, one quotient bit per cycle. Depends on nrg_pkg.
`timescale 1ns / 1ps

module nrg_coord #(
  parameter int MAX_DIM = nrg_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [$clog2(MAX_DIM)-1:0]  pos_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] n_in_i,
  input  logic [$clog2(MAX_DIM+1)-1:0] n_out_i,
  output logic                        done_o,
  output logic [$clog2(MAX_DIM)-1:0]  coord_o
);

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int NUM_W = CNT_W + 1 + DIM_W;
  localparam int REM_W = DIM_W + 2;
  localparam int SC_W  = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] den_q;
  logic [DIM_W-1:0] n_in_q;
  logic [SC_W-1:0]  step_q, step_d;
  logic             done_q, done_d;
  logic [REM_W-1:0] trial;
  logic [NUM_W-1:0] num;

  // ceil(a/b) - 1 == floor((a-1)/b) for a >= 1
  assign num   = NUM_W'({pos_i, 1'b1}) * NUM_W'(n_in_i) - NUM_W'(1);
  assign trial = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num;
      rem_d  = '0;
      step_d = SC_W'(NUM_W);
    end else if (step_q != '0) begin
      step_d = step_q - SC_W'(1);
      if (trial >= den_q) begin
        rem_d = trial - den_q;
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      done_d = (step_q == SC_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q  <= REM_W'({n_out_i, 1'b0});
      n_in_q <= n_in_i;
    end
  end

  assign done_o  = done_q;
  assign coord_o = (quo_q >= NUM_W'(n_in_q)) ? CNT_W'(n_in_q - DIM_W'(1)) : CNT_W'(quo_q);

endmodule

[rtl/nrg_store.sv]
// Pixel store: single write port, single registered read port.
// Contents are undefined until written. Depends on nrg_pkg.
`timescale 1ns / 1ps

module nrg_store #(
  parameter int STORE_DEPTH = nrg_pkg::STORE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]  waddr_i,
  input  logic [nrg_pkg::PIXEL_W-1:0]     wdata_i,
  input  logic                            re_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]  raddr_i,
  output logic [nrg_pkg::PIXEL_W-1:0]     rdata_o
);

  logic [nrg_pkg::PIXEL_W-1:0] mem [STORE_DEPTH];
  logic [nrg_pkg::PIXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
